// File: rtl/dma_channel_address_sequencer_macros.svh
// Assertion macros shared by the DMA channel address sequencer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DMA_CHANNEL_ADDRESS_SEQUENCER_MACROS_SVH
`define DMA_CHANNEL_ADDRESS_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DCAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DCAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dcas_pkg.sv
// Shared types, register codes and constants for the DMA channel address sequencer.
// No dependencies; imported by every module of the block.
package dcas_pkg;

    // Channel number; channel 3 has the larger maximum count
    localparam int unsigned CHANNEL = 0;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned REM_W       = 17;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 72;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_START  = 3'd0,
        REG_DEST_START    = 3'd1,
        REG_UNIT_COUNT    = 3'd2,
        REG_DEST_MODE     = 3'd3,
        REG_SOURCE_MODE   = 3'd4,
        REG_WIDE_UNITS    = 3'd5,
        REG_START_TIMING  = 3'd6,
        REG_CHANNEL_FLAGS = 3'd7
    } cfg_reg_t;

    // Address step modes
    localparam logic [1:0] MODE_INC     = 2'd0;
    localparam logic [1:0] MODE_DEC     = 2'd1;
    localparam logic [1:0] MODE_FIXED   = 2'd2;
    localparam logic [1:0] MODE_SPECIAL = 2'd3;

    // Start timing codes
    localparam logic [1:0] TIMING_IMMEDIATE = 2'd0;
    localparam logic [1:0] TIMING_VBLANK    = 2'd1;
    localparam logic [1:0] TIMING_HBLANK    = 2'd2;

    // Bits of channel_flags
    localparam int unsigned FLAG_IRQ    = 0;
    localparam int unsigned FLAG_REPEAT = 1;

    localparam logic [ADDR_W-1:0] LOW_REGION_LIMIT = 32'h0500_0000;
    localparam logic [ADDR_W-1:0] LOW_ADDR_MASK    = 32'h07FF_FFFF;
    localparam logic [ADDR_W-1:0] HIGH_ADDR_MASK   = 32'h0FFF_FFFF;
    localparam logic [ADDR_W-1:0] WORD_ALIGN_MASK  = ~32'h3;
    localparam logic [ADDR_W-1:0] HALF_ALIGN_MASK  = ~32'h1;
    localparam logic [ADDR_W-1:0] WORD_STEP        = 32'd4;
    localparam logic [ADDR_W-1:0] HALF_STEP        = 32'd2;
    localparam logic [REM_W-1:0]  MAX_COUNT_CH3    = 17'h1_0000;
    localparam logic [REM_W-1:0]  MAX_COUNT        = 17'h0_4000;
    localparam logic [REM_W-1:0]  DEFAULT_COUNT    = (CHANNEL == 3) ? MAX_COUNT_CH3 : MAX_COUNT;

    typedef struct packed {
        logic [ADDR_W-1:0]  source_start;
        logic [ADDR_W-1:0]  dest_start;
        logic [COUNT_W-1:0] unit_count;
        logic [1:0]         dest_mode;
        logic [1:0]         source_mode;
        logic               wide_units;
        logic [1:0]         start_timing;
        logic [1:0]         channel_flags;
    } cfg_t;

    typedef struct packed {
        logic hblank_event;
        logic vblank_event;
        logic arm;
    } in_item_t;

    typedef struct packed {
        logic              transfer_valid;
        logic [ADDR_W-1:0] read_address;
        logic [ADDR_W-1:0] write_address;
        logic              word_size;
        logic              last;
        logic              irq_pulse;
    } result_t;

    // Keep 27 bits below the I/O region boundary, 28 bits elsewhere
    function automatic logic [ADDR_W-1:0] mask_address(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] m;
        m = (a < LOW_REGION_LIMIT) ? (a & LOW_ADDR_MASK) : (a & HIGH_ADDR_MASK);
        return m;
    endfunction

endpackage

// File: rtl/dma_channel_address_sequencer.sv
// A slot beat accepted into the input register gives its result beat in the output
// register, from which it is offered on the master side.
// Throughput: one slot beat per cycle unless the master side stalls; the step path
// is one address add and one count decrement between the input and output registers.
// Reset: rst_n is asynchronous, active low; clears config, channel state and valid flags.
// Every accepted slot beat produces exactly one result beat, idle slots all zero.
module dma_channel_address_sequencer
    import dcas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Slot beats
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] arm, [1] vblank_event, [2] hblank_event
    // Result beats
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] read_address, [63:32] write_address,
                                                  // [64] word_size, [65] irq_pulse
    output logic                   m_axis_tlast,  // last
    output logic [0:0]             m_axis_tuser   // [0] transfer_valid
);

    cfg_t     cfg;
    result_t  result;
    logic     out_ready;
    logic     fire;
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;

    dcas_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held slot beat into the output register
    assign fire          = in_valid_reg & out_ready;
    assign s_axis_tready = ~in_valid_reg | fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid & s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid & s_axis_tready)
        begin
            in_item_reg <= in_item_t'(s_axis_tdata[2:0]);
        end
    end

    dcas_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    dcas_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .result        (result),
        .ready         (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: rtl/dcas_cfg_regs.sv
// Configuration register file of the DMA channel address sequencer.
// Depends on dcas_pkg for the register codes and the cfg_t layout.
module dcas_cfg_regs
    import dcas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SOURCE_START:  cfg_next.source_start  = cfg_data;
                REG_DEST_START:    cfg_next.dest_start    = cfg_data;
                REG_UNIT_COUNT:    cfg_next.unit_count    = cfg_data[COUNT_W-1:0];
                REG_DEST_MODE:     cfg_next.dest_mode     = cfg_data[1:0];
                REG_SOURCE_MODE:   cfg_next.source_mode   = cfg_data[1:0];
                REG_WIDE_UNITS:    cfg_next.wide_units    = cfg_data[0];
                REG_START_TIMING:  cfg_next.start_timing  = cfg_data[1:0];
                REG_CHANNEL_FLAGS: cfg_next.channel_flags = cfg_data[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/dcas_seq.sv
// Channel state and per-slot step logic: trigger, run start, address stepping, count.
// Depends on dcas_pkg and the assertion macros header.
`include "dma_channel_address_sequencer_macros.svh"

module dcas_seq
    import dcas_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     fire,
    input  in_item_t item,
    output result_t  result
);

    logic              armed_reg,   armed_next;
    logic              running_reg, running_next;
    logic [ADDR_W-1:0] source_reg,  source_next;
    logic [ADDR_W-1:0] dest_reg,    dest_next;
    logic [REM_W-1:0]  remain_reg,  remain_next;

    logic              armed_now;
    logic              trigger;
    logic              start;
    logic              run;
    logic [ADDR_W-1:0] source_cur;
    logic [ADDR_W-1:0] dest_cur;
    logic [REM_W-1:0]  remain_cur;
    logic [REM_W-1:0]  remain_dec;
    logic [ADDR_W-1:0] step;
    logic [ADDR_W-1:0] align;
    logic              is_last;

    // Trigger and run start
    always_comb
    begin
        armed_now = armed_reg | item.arm;
        trigger   = (cfg.start_timing == TIMING_IMMEDIATE)
                  | ((cfg.start_timing == TIMING_VBLANK) & item.vblank_event)
                  | ((cfg.start_timing == TIMING_HBLANK) & item.hblank_event);
        start     = ~running_reg & armed_now & trigger;
        run       = running_reg | start;
    end

    // Select the start values or the running values
    always_comb
    begin
        source_cur = start ? mask_address(cfg.source_start) : source_reg;
        dest_cur   = start ? mask_address(cfg.dest_start) : dest_reg;
        if (start)
        begin
            remain_cur = (cfg.unit_count != '0) ? {1'b0, cfg.unit_count} : DEFAULT_COUNT;
        end
        else
        begin
            remain_cur = remain_reg;
        end
        remain_dec = remain_cur - REM_W'(1);
        is_last    = run & (remain_dec == '0);
        step       = cfg.wide_units ? WORD_STEP : HALF_STEP;
        align      = cfg.wide_units ? WORD_ALIGN_MASK : HALF_ALIGN_MASK;
    end

    // Next state for one beat
    always_comb
    begin
        armed_next   = armed_reg;
        running_next = running_reg;
        source_next  = source_reg;
        dest_next    = dest_reg;
        remain_next  = remain_reg;
        if (fire)
        begin
            armed_next = armed_now;
            if (run)
            begin
                remain_next  = remain_dec;
                running_next = ~is_last;
                if (is_last)
                begin
                    armed_next = cfg.channel_flags[FLAG_REPEAT];
                end

                unique case (cfg.dest_mode)
                    MODE_INC:     dest_next = dest_cur + step;
                    MODE_DEC:     dest_next = dest_cur - step;
                    MODE_FIXED:   dest_next = dest_cur;
                    MODE_SPECIAL: dest_next = dest_cur + step;
                    default:      dest_next = dest_cur;
                endcase

                unique case (cfg.source_mode)
                    MODE_INC:     source_next = source_cur + step;
                    MODE_DEC:     source_next = source_cur - step;
                    MODE_FIXED:   source_next = source_cur;
                    MODE_SPECIAL: source_next = source_cur;
                    default:      source_next = source_cur;
                endcase
            end
        end
    end

    // Result of this slot; all zero when no transfer is issued
    always_comb
    begin
        result = '0;
        if (run)
        begin
            result.transfer_valid = 1'b1;
            result.read_address   = source_cur & align;
            result.write_address  = dest_cur & align;
            result.word_size      = cfg.wide_units;
            result.last           = is_last;
            result.irq_pulse      = is_last & cfg.channel_flags[FLAG_IRQ];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            running_reg <= 1'b0;
            source_reg  <= '0;
            dest_reg    <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            armed_reg   <= armed_next;
            running_reg <= running_next;
            source_reg  <= source_next;
            dest_reg    <= dest_next;
            remain_reg  <= remain_next;
        end
    end

    `DCAS_ASSERT_NEXT(a_last_ends_run, clk, rst_n, fire && result.last, !running_reg, "run still active after last transfer")
    `DCAS_ASSERT_NEXT(a_run_continues, clk, rst_n, fire && run && !result.last, running_reg, "run dropped before last transfer")
    `DCAS_ASSERT_NEXT(a_idle_keeps_count, clk, rst_n, fire && !run, remain_reg == $past(remain_reg), "count moved on an idle slot")
    `DCAS_ASSERT_NOW(a_start_needs_arm, clk, rst_n, start, armed_now && !running_reg, "run started without being armed")

endmodule

// File: rtl/dcas_out_stage.sv
// Output register of the DMA channel address sequencer: holds one result beat.
// Depends on dcas_pkg for result_t and the tdata width.
module dcas_out_stage
    import dcas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  result_t                result,
    output logic                   ready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic [0:0]             m_axis_tuser
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Free when empty or when the held beat leaves this cycle
    assign ready = ~valid_reg | m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'b0, data_reg.irq_pulse, data_reg.word_size,
                            data_reg.write_address, data_reg.read_address};
    assign m_axis_tlast  = data_reg.last;
    assign m_axis_tuser  = data_reg.transfer_valid;

endmodule
